@@ rtl/core/xor_parity_frame_fec_defines.svh @@
// Assertion macros used by the checker file.
// Each macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef XOR_PARITY_FRAME_FEC_DEFINES_SVH
`define XOR_PARITY_FRAME_FEC_DEFINES_SVH

// Same-cycle implication.
`define XPF_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("xpf same-cycle check failed");

// Next-cycle implication.
`define XPF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("xpf next-cycle check failed");

`endif

@@ rtl/core/xpf_pkg.sv @@
package xpf_pkg;

    // Frame geometry
    localparam int PAYLOAD_LEN  = 160;
    localparam int PERIOD       = 25;
    localparam int SEQ_BYTES    = 4;
    localparam int PARITY_START = 2;
    localparam int FRAME_LEN    = PAYLOAD_LEN + SEQ_BYTES;
    localparam int BANK_DEPTH   = 2 * PAYLOAD_LEN;

    localparam int POS_W  = $clog2(FRAME_LEN + 1);
    localparam int ADDR_W = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

    // Sequence residue modulo the parity period
    localparam int RES_W     = (PERIOD > 1) ? $clog2(PERIOD) : 1;
    localparam int RES_N     = 2 ** RES_W;
    localparam int RADIX_MOD = 256 % PERIOD;

    typedef logic [RES_W-1:0] res_t;
    typedef res_t byte_tbl_t [256];
    typedef res_t mul_tbl_t [RES_N];

    // Control from the byte pipeline to the residue tracker
    typedef struct packed {
        logic step;   // a sequence byte is transferred
        logic first;  // it is the first byte of the datagram
    } seq_ctl_t;

    // Residue of each byte value
    function automatic byte_tbl_t build_byte_tbl();
        byte_tbl_t t;
        for (int i = 0; i < 256; i++)
        begin
            t[i] = res_t'(i % PERIOD);
        end
        return t;
    endfunction

    // Residue of (r * 256) for each residue r
    function automatic mul_tbl_t build_mul_tbl();
        mul_tbl_t t;
        for (int i = 0; i < RES_N; i++)
        begin
            t[i] = res_t'((i * RADIX_MOD) % PERIOD);
        end
        return t;
    endfunction

    localparam byte_tbl_t BYTE_MOD = build_byte_tbl();
    localparam mul_tbl_t  MUL_MOD  = build_mul_tbl();

endpackage

@@ rtl/core/xpf_seq_mod.sv @@
module xpf_seq_mod
    import xpf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  seq_ctl_t   ctl,
    input  logic [7:0] data_byte,
    output logic       res_zero
);

    res_t             res_reg;
    res_t             res_next;
    res_t             shifted;
    logic [RES_W:0]   sum_wide;
    logic [RES_W:0]   sum_red;

    // Fold the next big-endian byte into the running residue
    always_comb
    begin
        shifted  = ctl.first ? '0 : MUL_MOD[res_reg];
        sum_wide = {1'b0, shifted} + {1'b0, BYTE_MOD[data_byte]};
        if (sum_wide >= (RES_W+1)'(PERIOD))
        begin
            sum_red = sum_wide - (RES_W+1)'(PERIOD);
        end
        else
        begin
            sum_red = sum_wide;
        end
        res_next = ctl.step ? res_t'(sum_red) : res_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_reg <= '0;
        end
        else
        begin
            res_reg <= res_next;
        end
    end

    assign res_zero = (res_reg == '0);

endmodule

@@ rtl/core/xor_parity_frame_fec.sv @@
// Byte-stream XOR parity generator: one datagram byte is taken per cycle, back to back,
// while in_stall is low, and each byte's result passes through the memory-read stage
// (the synchronous payload memory read) and then the output register. The single
// payload memory takes one write of the current bank and one read of the previous
// bank per accepted payload byte. The payload memory has no clearing pass: parity
// bytes only draw on it once a full frame has been accepted, so the block is ready right
// out of reset. The out_stall back-pressure reaches in_stall only when both the output
// register and the memory-read stage are full.
module xor_parity_frame_fec
    import xpf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_byte,
    input  logic       datagram_last,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] frame_byte,
    output logic       byte_in_frame,
    output logic [7:0] parity_byte,
    output logic       parity_byte_valid,
    output logic       end_of_datagram,
    output logic       frame_accepted,
    output logic       send_parity
);

    typedef struct packed {
        logic [7:0] data;
        logic       in_frame;
        logic       pvalid;
        logic       use_mem;
        logic       last;
        logic       accepted;
        logic       send;
    } item_t;

    // Frame state
    logic [POS_W-1:0]  pos_reg;
    logic [POS_W-1:0]  pos_next;
    logic              bank_sel_reg;
    logic              bank_sel_next;
    logic              have_prev_reg;
    logic              have_prev_next;

    // Pipeline
    logic              s1_valid_reg;
    logic              s1_valid_next;
    item_t             s1_reg;
    item_t             s1_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [7:0]        parity_calc;

    // Payload memory
    logic [7:0]        bank_mem [BANK_DEPTH];
    logic [7:0]        rd_data_reg;
    logic [POS_W-1:0]  off_pos;
    logic [ADDR_W-1:0] off;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;

    logic              in_accept;
    logic              s1_adv;
    logic              in_frame;
    logic              is_seq;
    logic              is_payload;
    logic              is_parity;
    logic              accepted_now;
    logic              res_zero;
    seq_ctl_t          seq_ctl;

    // Handshake
    assign s1_adv    = !out_valid_reg || !out_stall;
    assign in_stall  = s1_valid_reg && !s1_adv;
    assign in_accept = in_valid && !in_stall;

    // Decode the byte position
    assign in_frame     = pos_reg < POS_W'(FRAME_LEN);
    assign is_seq       = pos_reg < POS_W'(SEQ_BYTES);
    assign is_payload   = in_frame && !is_seq;
    assign is_parity    = in_frame && (pos_reg >= POS_W'(PARITY_START));
    assign accepted_now = datagram_last && (pos_reg >= POS_W'(FRAME_LEN - 1));

    // Bank addresses: write the current bank, read the previous one
    assign off_pos = pos_reg - POS_W'(SEQ_BYTES);
    assign off     = ADDR_W'(off_pos);
    assign wr_addr = bank_sel_reg ? off + ADDR_W'(PAYLOAD_LEN) : off;
    assign rd_addr = bank_sel_reg ? off : off + ADDR_W'(PAYLOAD_LEN);

    // Sequence residue tracker
    assign seq_ctl.step  = in_accept && is_seq;
    assign seq_ctl.first = (pos_reg == '0);

    xpf_seq_mod u_seq_mod
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (seq_ctl),
        .data_byte (data_byte),
        .res_zero  (res_zero)
    );

    // Advance frame state on each transfer
    always_comb
    begin
        pos_next       = pos_reg;
        bank_sel_next  = bank_sel_reg;
        have_prev_next = have_prev_reg;
        if (in_accept)
        begin
            if (datagram_last)
            begin
                pos_next = '0;
            end
            else if (in_frame)
            begin
                pos_next = pos_reg + POS_W'(1);
            end
            if (accepted_now)
            begin
                bank_sel_next  = !bank_sel_reg;
                have_prev_next = 1'b1;
            end
        end
    end

    // Capture the item for the memory-read stage
    always_comb
    begin
        s1_next.data     = data_byte;
        s1_next.in_frame = in_frame;
        s1_next.pvalid   = is_parity;
        s1_next.use_mem  = is_payload && have_prev_reg;
        s1_next.last     = datagram_last;
        s1_next.accepted = accepted_now;
        s1_next.send     = accepted_now && have_prev_reg && !res_zero;
    end

    // Pipeline valid bits
    always_comb
    begin
        if (in_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
        out_valid_next = s1_adv ? s1_valid_reg : out_valid_reg;
    end

    // XOR with the same-position payload byte of the previous frame, once one is stored
    always_comb
    begin
        if (!s1_reg.pvalid)
        begin
            parity_calc = '0;
        end
        else if (s1_reg.use_mem)
        begin
            parity_calc = s1_reg.data ^ rd_data_reg;
        end
        else
        begin
            parity_calc = s1_reg.data;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            bank_sel_reg  <= 1'b0;
            have_prev_reg <= 1'b0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            bank_sel_reg  <= bank_sel_next;
            have_prev_reg <= have_prev_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload memory: write the current byte, read the previous bank
    always_ff @(posedge clk)
    begin
        if (in_accept && is_payload)
        begin
            bank_mem[wr_addr] <= data_byte;
        end
        if (in_accept && is_payload && have_prev_reg)
        begin
            rd_data_reg <= bank_mem[rd_addr];
        end
    end

    // Stage and output payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_reg <= s1_next;
        end
        if (s1_adv && s1_valid_reg)
        begin
            frame_byte        <= s1_reg.data;
            byte_in_frame     <= s1_reg.in_frame;
            parity_byte       <= parity_calc;
            parity_byte_valid <= s1_reg.pvalid;
            end_of_datagram   <= s1_reg.last;
            frame_accepted    <= s1_reg.accepted;
            send_parity       <= s1_reg.send;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

@@ rtl/core/xpf_checker.sv @@
`include "xor_parity_frame_fec_defines.svh"

module xpf_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] frame_byte,
    input logic       byte_in_frame,
    input logic [7:0] parity_byte,
    input logic       parity_byte_valid,
    input logic       end_of_datagram,
    input logic       frame_accepted,
    input logic       send_parity
);

    // Hold a stalled result
    `XPF_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(frame_byte) && $stable(parity_byte) && $stable(end_of_datagram))

    // Decision flags only on the last byte
    `XPF_ASSERT_NOW(a_flags_at_end, out_valid && !end_of_datagram, !frame_accepted && !send_parity)

    // Parity goes out only for an accepted frame
    `XPF_ASSERT_NOW(a_send_needs_accept, out_valid && send_parity, frame_accepted)

    // Drop parity outside its window
    `XPF_ASSERT_NOW(a_parity_zero, out_valid && !parity_byte_valid, parity_byte == 8'd0)

    // Parity bytes lie within the frame
    `XPF_ASSERT_NOW(a_parity_in_frame, out_valid && parity_byte_valid, byte_in_frame)

endmodule

bind xor_parity_frame_fec xpf_checker u_xpf_checker (.*);
